// ===== src/line_pixel_generator_assert.svh =====
// Assertion macros used by the line pixel generator checker
`ifndef LINE_PIXEL_GENERATOR_ASSERT_SVH
`define LINE_PIXEL_GENERATOR_ASSERT_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low
`define LPG_ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while rst_ni is low
`define LPG_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/lpg_pkg.sv =====
// Types and constants of the line pixel generator
package lpg_pkg;

  localparam int unsigned CoordBits = 8;
  localparam int unsigned ColorBits = 16;
  localparam int unsigned StraightW = CoordBits + 2;
  localparam int unsigned DiagW     = CoordBits + 3;
  localparam int unsigned DecW      = CoordBits + 10;

  typedef enum logic [0:0] {
    ModeLoad    = 1'b0,
    ModeAdvance = 1'b1
  } mode_e;

  typedef struct packed {
    mode_e                  mode;
    logic [CoordBits-1:0]   x_start;
    logic [CoordBits-1:0]   y_start;
    logic [CoordBits-1:0]   x_end;
    logic [CoordBits-1:0]   y_end;
    logic [ColorBits-1:0]   line_color;
  } line_in_t;

  typedef struct packed {
    logic [CoordBits-1:0]   pixel_x;
    logic [CoordBits-1:0]   pixel_y;
    logic [ColorBits-1:0]   pixel_color;
    logic                   last_pixel;
  } pixel_out_t;

endpackage

// ===== src/line_pixel_generator.sv =====
// Line pixel generator: first-octant midpoint line rasterizer, at most one pixel per word
//
//   channel  dir  handshake                 payload
//   in       in   in_valid_i / in_ready_o   in_data_i  (line_in_t)
//   out      out  out_valid_o / out_ready_i out_data_o (pixel_out_t)
//
// One word per cycle while in_ready_o; a pixel is registered next cycle (output or skid).
// Line state updates in one pass: an add of the decision term and a compare on the major axis.
// A two-entry output buffer (output register plus skid) keeps in_ready_o high while one
// pixel waits; in_ready_o drops only when both entries are full.
// rst_ni clears the line state and empties the output buffer.
module line_pixel_generator
  import lpg_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  line_in_t   in_data_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output pixel_out_t out_data_o
);

  // line state
  logic                        line_active_q, line_active_d;
  logic [CoordBits-1:0]        cur_major_q, cur_major_d;
  logic [CoordBits-1:0]        cur_minor_q, cur_minor_d;
  logic [CoordBits-1:0]        stop_major_q, stop_major_d;
  logic signed [DecW-1:0]      decision_q, decision_d;
  logic signed [StraightW-1:0] straight_q, straight_d;
  logic signed [DiagW-1:0]     diagonal_q, diagonal_d;
  logic [ColorBits-1:0]        color_q, color_d;

  // output buffer
  pixel_out_t out_q, out_d, skid_q, skid_d;
  logic       out_valid_q, out_valid_d, skid_valid_q, skid_valid_d;

  logic                        accept, push, pop;
  pixel_out_t                  result;
  logic signed [CoordBits:0]   dx, dy;
  logic signed [DecW-1:0]      dx_ext, dy_ext;
  logic [CoordBits-1:0]        major_inc;
  logic                        step_diag;

  assign in_ready_o = !skid_valid_q;
  assign accept     = in_valid_i && in_ready_o;
  assign pop        = out_valid_q && out_ready_i;

  assign dx = signed'({1'b0, in_data_i.x_end}) - signed'({1'b0, in_data_i.x_start});
  assign dy = signed'({1'b0, in_data_i.y_end}) - signed'({1'b0, in_data_i.y_start});
  assign dx_ext = {{(DecW-CoordBits-1){dx[CoordBits]}}, dx};
  assign dy_ext = {{(DecW-CoordBits-1){dy[CoordBits]}}, dy};

  assign major_inc = cur_major_q + CoordBits'(1);
  // move diagonally when the decision term is strictly positive
  assign step_diag = !decision_q[DecW-1] && (|decision_q);

  always_comb begin
    line_active_d = line_active_q;
    cur_major_d   = cur_major_q;
    cur_minor_d   = cur_minor_q;
    stop_major_d  = stop_major_q;
    decision_d    = decision_q;
    straight_d    = straight_q;
    diagonal_d    = diagonal_q;
    color_d       = color_q;
    push          = 1'b0;
    result        = '0;
    if (accept) begin
      if (in_data_i.mode == ModeLoad) begin
        cur_major_d   = in_data_i.x_start;
        cur_minor_d   = in_data_i.y_start;
        stop_major_d  = in_data_i.x_end;
        color_d       = in_data_i.line_color;
        straight_d    = {dy, 1'b0};
        diagonal_d    = {dy[CoordBits], dy, 1'b0} - {dx[CoordBits], dx, 1'b0};
        decision_d    = (dy_ext <<< 1) - dx_ext;
        line_active_d = in_data_i.x_start < in_data_i.x_end;
        push          = 1'b1;
        result.pixel_x     = in_data_i.x_start;
        result.pixel_y     = in_data_i.y_start;
        result.pixel_color = in_data_i.line_color;
        result.last_pixel  = !line_active_d;
      end else if (line_active_q) begin
        cur_major_d = major_inc;
        if (step_diag) begin
          cur_minor_d = cur_minor_q + CoordBits'(1);
          decision_d  = decision_q + {{(DecW-DiagW){diagonal_q[DiagW-1]}}, diagonal_q};
        end else begin
          decision_d  = decision_q + {{(DecW-StraightW){straight_q[StraightW-1]}}, straight_q};
        end
        line_active_d = major_inc != stop_major_q;
        push          = 1'b1;
        result.pixel_x     = cur_major_d;
        result.pixel_y     = cur_minor_d;
        result.pixel_color = color_q;
        result.last_pixel  = !line_active_d;
      end
    end
  end

  // push never coincides with a full skid, since in_ready_o is low then
  always_comb begin
    out_d        = out_q;
    out_valid_d  = out_valid_q;
    skid_d       = skid_q;
    skid_valid_d = skid_valid_q;
    if (pop) begin
      if (skid_valid_q) begin
        out_d        = skid_q;
        skid_valid_d = 1'b0;
      end else if (push) begin
        out_d = result;
      end else begin
        out_valid_d = 1'b0;
      end
    end else if (push) begin
      if (!out_valid_q) begin
        out_d       = result;
        out_valid_d = 1'b1;
      end else begin
        skid_d       = result;
        skid_valid_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_active_q <= 1'b0;
      cur_major_q   <= '0;
      cur_minor_q   <= '0;
      stop_major_q  <= '0;
      decision_q    <= '0;
      straight_q    <= '0;
      diagonal_q    <= '0;
      color_q       <= '0;
      out_valid_q   <= 1'b0;
      skid_valid_q  <= 1'b0;
    end else begin
      line_active_q <= line_active_d;
      cur_major_q   <= cur_major_d;
      cur_minor_q   <= cur_minor_d;
      stop_major_q  <= stop_major_d;
      decision_q    <= decision_d;
      straight_q    <= straight_d;
      diagonal_q    <= diagonal_d;
      color_q       <= color_d;
      out_valid_q   <= out_valid_d;
      skid_valid_q  <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ===== src/lpg_checker.sv =====
// Port-level checker for the line pixel generator, bound to the top level
`include "line_pixel_generator_assert.svh"

module lpg_checker
  import lpg_pkg::*;
(
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_i,
  input line_in_t   in_data_i,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input pixel_out_t out_data_i
);

  logic load_word;
  logic in_stall;
  logic degenerate_load;
  logic out_stall;
  assign load_word = in_valid_i && in_ready_i && (in_data_i.mode == ModeLoad);
  assign in_stall  = !in_ready_i;
  assign degenerate_load = load_word && !out_valid_i &&
                           (in_data_i.x_start >= in_data_i.x_end);
  assign out_stall = out_valid_i && !out_ready_i;

  // backpressure on the input only once a pixel is already waiting
  `LPG_ASSERT_IMPLY(a_stall_needs_backlog, in_stall, out_valid_i, "input stalled, no pixel")

  // a load always yields its start pixel
  `LPG_ASSERT_NEXT(a_load_emits, load_word, out_valid_i, "load word produced no pixel")

  // a degenerate line is a single flagged pixel, seen at once when the output was free
  `LPG_ASSERT_NEXT(a_degenerate_last, degenerate_load, out_data_i.last_pixel, "not flagged last")

  `LPG_ASSERT_NEXT(a_out_hold, out_stall, out_valid_i && $stable(out_data_i), "pixel changed")

endmodule

bind line_pixel_generator lpg_checker u_lpg_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_i  (in_ready_o),
  .in_data_i   (in_data_i),
  .out_valid_i (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_i  (out_data_o)
);

// ===== tb/line_pixel_generator_tb.sv =====
// Testbench for the line pixel generator: directed and random lines, checked against a predictor
`timescale 1ns / 100ps

module line_pixel_generator_tb;
  import lpg_pkg::*;

  localparam int unsigned WatchdogLimit = 3000;
  localparam int unsigned LongHold      = 200;
  localparam int unsigned RandomPixels  = 900;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid_i = 1'b0;
  logic       in_ready_o;
  line_in_t   in_data_i = '0;
  logic       out_valid_o;
  logic       out_ready_i = 1'b0;
  pixel_out_t out_data_o;

  line_pixel_generator u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Rasterizer state mirrored by the predictor
  logic                        line_on;
  logic [CoordBits-1:0]        major_pos, minor_pos, major_stop;
  logic signed [DecW-1:0]      decision;
  logic signed [StraightW-1:0] step_straight;
  logic signed [DiagW-1:0]     step_diag;
  logic [ColorBits-1:0]        pen_color;

  pixel_out_t expected_pixels[$];
  int         pixels_queued = 0;
  int         mismatch_count = 0;
  int         quiet_cycles = 0;
  bit         hold_request = 1'b0;
  bit         sender_no_idle = 1'b0;
  bit         sink_no_idle = 1'b0;

  function automatic bit predict_pixel(input line_in_t w, output pixel_out_t px);
    int dx, dy;
    px = '0;
    if (w.mode == ModeLoad) begin
      dx = int'(w.x_end) - int'(w.x_start);
      dy = int'(w.y_end) - int'(w.y_start);
      pen_color     = w.line_color;
      major_pos     = w.x_start;
      minor_pos     = w.y_start;
      major_stop    = w.x_end;
      step_straight = StraightW'(2 * dy);
      step_diag     = DiagW'(2 * dy - 2 * dx);
      decision      = DecW'(2 * dy - dx);
      line_on       = (w.x_start < w.x_end);
      px = '{pixel_x: major_pos, pixel_y: minor_pos, pixel_color: pen_color,
             last_pixel: !line_on};
      return 1'b1;
    end
    if (!line_on) return 1'b0;
    major_pos = major_pos + 1'b1;
    if (decision > 0) begin
      minor_pos = minor_pos + 1'b1;
      decision  = decision + step_diag;
    end else begin
      decision  = decision + step_straight;
    end
    if (major_pos == major_stop) line_on = 1'b0;
    px = '{pixel_x: major_pos, pixel_y: minor_pos, pixel_color: pen_color,
           last_pixel: (major_pos == major_stop)};
    return 1'b1;
  endfunction

  // Mostly no gap, some short, a few long
  function automatic int idle_length(bit no_idle);
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic line_in_t load_word(int xs, int ys, int xe, int ye, int c);
    line_in_t w;
    w.mode       = ModeLoad;
    w.x_start    = xs[CoordBits-1:0];
    w.y_start    = ys[CoordBits-1:0];
    w.x_end      = xe[CoordBits-1:0];
    w.y_end      = ye[CoordBits-1:0];
    w.line_color = c[ColorBits-1:0];
    return w;
  endfunction

  // Random word, forced to advance if asked; advance words carry junk in the unused fields
  function automatic line_in_t random_word(bit advance);
    logic [63:0] raw;
    line_in_t    w;
    raw = {$urandom, $urandom};
    w = raw[$bits(line_in_t)-1:0];
    if (advance) w.mode = ModeAdvance;
    return w;
  endfunction

  // Called at a rising edge; returns at the edge where the word is taken
  task automatic send_word(input line_in_t w);
    pixel_out_t px;
    int         gap;
    gap = idle_length(sender_no_idle);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= w;
    do @(posedge clk_i); while (!in_ready_o);
    if (predict_pixel(w, px)) begin
      expected_pixels.push_back(px);
      pixels_queued++;
    end
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (expected_pixels.size() != 0) @(posedge clk_i);
  endtask

  task automatic send_random_line();
    line_in_t w;
    int       len, xs, ys, ye, steps, r;
    r = $urandom_range(0, 99);
    if (r < 5) begin
      send_word(random_word(1'($urandom_range(0, 1))));
      return;
    end
    if (r < 12) begin
      w = random_word(1'b0);
      send_word(w);
      steps = (w.x_end > w.x_start) ? int'(w.x_end) - int'(w.x_start) : 0;
    end else begin
      len = ($urandom_range(0, 99) < 88) ? $urandom_range(0, 16) : $urandom_range(17, 255);
      xs  = $urandom_range(0, 255 - len);
      ys  = $urandom_range(0, 255);
      if ($urandom_range(0, 99) < 80) begin
        ye = ys + $urandom_range(0, len);
        if (ye > 255) ye = 255;
      end else begin
        ye = $urandom_range(0, 255);
      end
      send_word(load_word(xs, ys, xs + len, ye, $urandom_range(0, 65535)));
      steps = len;
    end
    // cut some lines short (next load abandons them), overrun a few
    r = $urandom_range(0, 99);
    if (r < 10 && steps > 0) steps = $urandom_range(0, steps - 1);
    else if (r < 18) steps = steps + $urandom_range(1, 2);
    repeat (steps) send_word(random_word(1'b1));
  endtask

  task automatic test_directed_lines();
    send_word(random_word(1'b1));                          // advance with no line
    send_word(load_word(0, 0, 0, 0, 16'h0000));            // single-point line
    send_word(random_word(1'b1));
    send_word(load_word(255, 255, 0, 0, 16'hFFFF));        // backward line
    send_word(load_word(251, 0, 255, 0, 16'hFFFF));        // flat, ends at the top of x
    repeat (5) send_word(random_word(1'b1));               // last one is ignored
    send_word(load_word(0, 0, 3, 3, 16'h5A5A));            // diagonal
    repeat (3) send_word(random_word(1'b1));
    send_word(load_word(10, 250, 12, 255, 16'h1234));      // steeper than 45 degrees
    repeat (2) send_word(random_word(1'b1));
    send_word(load_word(0, 255, 3, 0, 16'h8001));          // falling line
    send_word(random_word(1'b1));
    send_word(load_word(100, 100, 102, 101, 16'h7FFE));    // load mid-line
    repeat (2) send_word(random_word(1'b1));
    send_word(load_word(254, 255, 255, 255, 16'hC3C3));
    send_word(random_word(1'b1));
  endtask

  task automatic test_random_lines();
    int target, i;
    target = pixels_queued + RandomPixels;
    i = 0;
    while (pixels_queued < target) begin
      // every so often a stretch with no idling on either side
      if (i % 40 == 20) begin
        sender_no_idle = 1'b1;
        sink_no_idle   = 1'b1;
      end else if (i % 40 == 28) begin
        sender_no_idle = 1'b0;
        sink_no_idle   = 1'b0;
      end
      send_random_line();
      i++;
    end
    sender_no_idle = 1'b0;
    sink_no_idle   = 1'b0;
  endtask

  // Receiver holds off long while the sender keeps streaming a long line
  task automatic test_output_stall();
    hold_request   = 1'b1;
    sender_no_idle = 1'b1;
    send_word(load_word(0, 0, 200, 77, $urandom_range(0, 65535)));
    repeat (40) send_word(random_word(1'b1));
    sender_no_idle = 1'b0;
  endtask

  // Sender waits for every pending pixel, then resumes
  task automatic test_pause_and_resume();
    wait_drained();
    repeat (12) send_random_line();
  endtask

  // Receiver side
  initial begin
    int stall;
    forever begin
      @(posedge clk_i);
      if (!rst_ni) begin
        out_ready_i <= 1'b0;
      end else if (hold_request) begin
        hold_request = 1'b0;
        out_ready_i <= 1'b0;
        repeat (LongHold) @(posedge clk_i);
        out_ready_i <= 1'b1;
      end else if (sink_no_idle || $urandom_range(0, 99) < 70) begin
        out_ready_i <= 1'b1;
      end else begin
        stall = idle_length(1'b0);
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
    end
  end

  // Pixel checker and watchdog
  always @(posedge clk_i) begin
    pixel_out_t exp_px;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_pixels.size() == 0) begin
        $display("%0t: unexpected pixel x=%0d y=%0d color=%h last=%b", $time,
                 out_data_o.pixel_x, out_data_o.pixel_y, out_data_o.pixel_color,
                 out_data_o.last_pixel);
        mismatch_count++;
      end else begin
        exp_px = expected_pixels.pop_front();
        if (out_data_o.pixel_x !== exp_px.pixel_x) begin
          $display("%0t: pixel_x expected %0d actual %0d", $time, exp_px.pixel_x,
                   out_data_o.pixel_x);
          mismatch_count++;
        end
        if (out_data_o.pixel_y !== exp_px.pixel_y) begin
          $display("%0t: pixel_y expected %0d actual %0d", $time, exp_px.pixel_y,
                   out_data_o.pixel_y);
          mismatch_count++;
        end
        if (out_data_o.pixel_color !== exp_px.pixel_color) begin
          $display("%0t: pixel_color expected %h actual %h", $time, exp_px.pixel_color,
                   out_data_o.pixel_color);
          mismatch_count++;
        end
        if (out_data_o.last_pixel !== exp_px.last_pixel) begin
          $display("%0t: last_pixel expected %b actual %b", $time, exp_px.last_pixel,
                   out_data_o.last_pixel);
          mismatch_count++;
        end
      end
    end
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= WatchdogLimit) begin
      $display("%0t: watchdog, no word moved for %0d cycles", $time, quiet_cycles);
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    line_on       = 1'b0;
    major_pos     = '0;
    minor_pos     = '0;
    major_stop    = '0;
    decision      = '0;
    step_straight = '0;
    step_diag     = '0;
    pen_color     = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_lines();
    test_random_lines();
    test_output_stall();
    test_pause_and_resume();

    wait_drained();
    repeat (10) @(posedge clk_i);
    if (expected_pixels.size() != 0) begin
      $display("%0t: %0d pixels never arrived", $time, expected_pixels.size());
      mismatch_count++;
    end
    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
